// File: rtl/cache_set_lru_lookup_fill_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cache set lookup and fill block
// Implication and next-cycle implication forms with a reset term.
// ----------------------------------------------------------------------------
`ifndef CACHE_SET_LRU_LOOKUP_FILL_ASSERT_SVH
`define CACHE_SET_LRU_LOOKUP_FILL_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define CSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while rst_n is low
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and codes for the cache set lookup and fill block.
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam int LOOKUP_TAG_W = 8;
    localparam int WAY_INDEX_W  = 2;

    localparam logic OP_ACCESS     = 1'b0;
    localparam logic OP_INVALIDATE = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [LOOKUP_TAG_W-1:0] lookup_tag;
    } t_in;

    typedef struct packed {
        logic                   hit;
        logic [WAY_INDEX_W-1:0] way_index;
    } t_out;

    // result of one pass of the shared way compare unit
    typedef struct packed {
        logic match;
        logic older;
    } t_cmp_res;

endpackage

// File: rtl/cache_set_lru_lookup_fill.sv
// ----------------------------------------------------------------------------
// cache_set_lru_lookup_fill
// One set of a set-associative cache with age-counter replacement.
//
// Input channel (i_in_*): one transaction per access or invalidate. An
// access compares its tag with each way in turn; on a miss it fills the next
// unfilled way, or once the set is full the lowest valid way with the
// greatest nonzero age (way 0 if none). The used way's age is cleared and
// every other valid way ages by one, saturating. Invalidate clears valid
// bits, ages and the fill count; stored tags are kept.
// Output channel (o_out_*): one result per input transaction, hit flag and
// way number, held in an output register.
// Sequencing: an access scans one way per cycle through the shared compare
// unit, then a finish state writes its result to the output register; an
// invalidate goes straight to the finish state. o_in_ready is high only
// while the sequencer is idle, so a new transaction waits for the last one.
// Stall: a finished result waits in the output register; a further item may
// be accepted, but its final update stalls until the register drains.
// Reset clears valid bits, ages, fill count and the output valid flag.
// ----------------------------------------------------------------------------
module cache_set_lru_lookup_fill #(
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 8,
    parameter int AGE_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  csl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output csl_pkg::t_out o_out_data
);

    localparam int IDX_W  = $clog2(WAYS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int WIDE_W = (IDX_W > csl_pkg::WAY_INDEX_W) ? IDX_W : csl_pkg::WAY_INDEX_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_op, n_op;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_hit_way, n_hit_way;
    logic [AGE_BITS-1:0] r_best_age, n_best_age;
    logic [IDX_W-1:0]    r_best_way, n_best_way;
    logic [WAYS-1:0]     r_valid, n_valid;
    logic [TAG_BITS-1:0] r_tag_mem [WAYS];
    logic [AGE_BITS-1:0] r_age [WAYS];
    logic [AGE_BITS-1:0] n_age [WAYS];
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_out_valid, n_out_valid;
    csl_pkg::t_out       r_out_data, n_out_data;

    csl_pkg::t_cmp_res   cmp_res;
    logic                in_accept;
    logic                slot_free;
    logic                set_full;
    logic                tag_write;
    logic [IDX_W-1:0]    used_way;
    logic [WIDE_W-1:0]   used_wide;

    csl_way_cmp #(
        .TAG_BITS (TAG_BITS),
        .AGE_BITS (AGE_BITS)
    ) u_cmp (
        .i_way_valid  (r_valid[r_idx]),
        .i_way_tag    (r_tag_mem[r_idx]),
        .i_way_age    (r_age[r_idx]),
        .i_lookup_tag (r_tag),
        .i_best_age   (r_best_age),
        .o_res        (cmp_res)
    );

    assign in_accept = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign set_full  = (r_fill >= FILL_W'(WAYS));

    always_comb begin
        if (r_found) begin
            used_way = r_hit_way;
        end else if (!set_full) begin
            used_way = r_fill[IDX_W-1:0];
        end else begin
            used_way = r_best_way;
        end
        used_wide = WIDE_W'(used_way);
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_op        = r_op;
        n_tag       = r_tag;
        n_found     = r_found;
        n_hit_way   = r_hit_way;
        n_best_age  = r_best_age;
        n_best_way  = r_best_way;
        n_valid     = r_valid;
        n_fill      = r_fill;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        tag_write   = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            n_age[w] = r_age[w];
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_op       = i_in_data.operation;
                    n_tag      = TAG_BITS'(i_in_data.lookup_tag);
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_hit_way  = '0;
                    n_best_age = '0;
                    n_best_way = '0;
                    if (i_in_data.operation == csl_pkg::OP_INVALIDATE) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cmp_res.match && !r_found) begin
                    n_found   = 1'b1;
                    n_hit_way = r_idx;
                end
                if (cmp_res.older) begin
                    n_best_age = r_age[r_idx];
                    n_best_way = r_idx;
                end
                if (r_idx == IDX_W'(WAYS - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_op == csl_pkg::OP_INVALIDATE) begin
                        n_valid              = '0;
                        n_fill               = '0;
                        n_out_data.hit       = 1'b0;
                        n_out_data.way_index = '0;
                        for (int w = 0; w < WAYS; w++) begin
                            n_age[w] = '0;
                        end
                    end else begin
                        if (!r_found) begin
                            tag_write         = 1'b1;
                            n_valid[used_way] = 1'b1;
                            if (!set_full) begin
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        for (int w = 0; w < WAYS; w++) begin
                            if (n_valid[w]) begin
                                if (IDX_W'(w) == used_way) begin
                                    n_age[w] = '0;
                                end else if (r_age[w] != '1) begin
                                    n_age[w] = r_age[w] + 1'b1;
                                end
                            end
                        end
                        n_out_data.hit       = r_found;
                        n_out_data.way_index = used_wide[csl_pkg::WAY_INDEX_W-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            for (int w = 0; w < WAYS; w++) begin
                r_age[w] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            for (int w = 0; w < WAYS; w++) begin
                r_age[w] <= n_age[w];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_op       <= n_op;
        r_tag      <= n_tag;
        r_found    <= n_found;
        r_hit_way  <= n_hit_way;
        r_best_age <= n_best_age;
        r_best_way <= n_best_way;
        r_out_data <= n_out_data;
        if (tag_write) begin
            r_tag_mem[used_way] <= r_tag;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/csl_way_cmp.sv
// ----------------------------------------------------------------------------
// csl_way_cmp
// Shared compare unit: tag match and age ordering for one way per cycle.
// ----------------------------------------------------------------------------
module csl_way_cmp #(
    parameter int TAG_BITS = 8,
    parameter int AGE_BITS = 8
) (
    input  logic                i_way_valid,
    input  logic [TAG_BITS-1:0] i_way_tag,
    input  logic [AGE_BITS-1:0] i_way_age,
    input  logic [TAG_BITS-1:0] i_lookup_tag,
    input  logic [AGE_BITS-1:0] i_best_age,
    output csl_pkg::t_cmp_res   o_res
);

    always_comb begin
        o_res.match = i_way_valid && (i_way_tag == i_lookup_tag);
        o_res.older = i_way_valid && (i_way_age > i_best_age);
    end

endmodule

// File: rtl/cache_set_lru_lookup_fill_chk.sv
// ----------------------------------------------------------------------------
// cache_set_lru_lookup_fill_chk
// Port-level checks for the cache set lookup and fill block, bound to it.
// ----------------------------------------------------------------------------
`include "cache_set_lru_lookup_fill_assert.svh"

module cache_set_lru_lookup_fill_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input csl_pkg::t_out o_out_data
);

    logic in_accept;
    logic out_stall;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    `CSL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid)
    `CSL_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(o_out_data))
    `CSL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !o_in_ready)
    `CSL_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, o_in_ready && !o_out_valid)

endmodule

bind cache_set_lru_lookup_fill cache_set_lru_lookup_fill_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the cache set lookup and fill block
// Drives access and invalidate transactions through the input channel and
// predicts hit and way for each one from a local copy of the set: valid
// bits, tags, age counters and fill count. Results are compared in order.
// Stimulus opens with directed cases: fill order, hits, eviction of the
// oldest way, invalidate and tag extremes. Random segments follow: working
// sets of a few tags, long runs that saturate the ages, and noise. Both
// channels idle at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_WAYS     = 4;
    localparam int TAG_W        = 8;
    localparam int AGE_W        = 8;
    localparam int LOOKUP_W     = csl_pkg::LOOKUP_TAG_W;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int TOTAL_ITEMS  = 1040;
    localparam int DRAIN_CYCLES = 4 * (NUM_WAYS + 2);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        csl_pkg::t_in txn;
        int           gap;
        bit           drain_first;
    } t_request;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    csl_pkg::t_in  in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    csl_pkg::t_out out_data;

    t_request      access_stream [$];
    csl_pkg::t_out awaited_results [$];

    logic             way_live [NUM_WAYS];
    logic [TAG_W-1:0] way_tag  [NUM_WAYS];
    logic [AGE_W-1:0] way_age  [NUM_WAYS];
    int               ways_filled;

    int queued_total     = 0;
    int source_calm_left = 0;
    int sink_calm_left   = 0;
    int hold_cycles      = 0;
    bit hold_armed       = 1'b0;
    int stall_left       = 0;
    int results_seen     = 0;
    int fault_count      = 0;
    int cycle_count      = 0;

    cache_set_lru_lookup_fill #(
        .WAYS     (NUM_WAYS),
        .TAG_BITS (TAG_W),
        .AGE_BITS (AGE_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic csl_pkg::t_out resolve_set_access(csl_pkg::t_in txn);
        csl_pkg::t_out    res;
        int               used;
        bit               found;
        logic [AGE_W-1:0] oldest;
        res    = '0;
        used   = 0;
        found  = 1'b0;
        oldest = '0;
        if (txn.operation == csl_pkg::OP_INVALIDATE) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                way_live[w] = 1'b0;
                way_age[w]  = '0;
            end
            ways_filled = 0;
            return res;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && way_live[w] && way_tag[w] == txn.lookup_tag) begin
                used  = w;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (ways_filled < NUM_WAYS) begin
                used = ways_filled;
                ways_filled++;
            end else begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (way_live[w] && way_age[w] > oldest) begin
                        oldest = way_age[w];
                        used   = w;
                    end
                end
            end
            way_tag[used]  = txn.lookup_tag;
            way_live[used] = 1'b1;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_live[w]) begin
                if (w == used) begin
                    way_age[w] = '0;
                end else if (way_age[w] != '1) begin
                    way_age[w] = way_age[w] + 1'b1;
                end
            end
        end
        res.hit       = found;
        res.way_index = used[csl_pkg::WAY_INDEX_W-1:0];
        return res;
    endfunction

    task automatic queue_request(logic op, logic [LOOKUP_W-1:0] tag, bit drain);
        t_request req;
        req.txn.operation  = op;
        req.txn.lookup_tag = tag;
        req.drain_first    = drain;
        if (source_calm_left > 0) begin
            source_calm_left--;
            req.gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            source_calm_left = $urandom_range(20, 60);
            req.gap = 0;
        end else begin
            req.gap = $urandom_range(0, 13);
        end
        access_stream.push_back(req);
        queued_total++;
    endtask

    always @(posedge clk) begin
        bit fire;
        fire = in_valid && in_ready;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (fire) begin
                awaited_results.push_back(resolve_set_access(in_data));
            end
            if (!in_valid || fire) begin
                if (access_stream.size() != 0 && !hold_armed) begin
                    hold_cycles = access_stream[0].gap;
                    hold_armed  = 1'b1;
                end
                if (access_stream.size() != 0 && hold_cycles == 0 &&
                    !(access_stream[0].drain_first && awaited_results.size() != 0)) begin
                    in_data    <= access_stream[0].txn;
                    in_valid   <= 1'b1;
                    hold_armed  = 1'b0;
                    void'(access_stream.pop_front());
                end else begin
                    in_valid <= 1'b0;
                    if (hold_cycles > 0) hold_cycles--;
                end
            end
        end
    end

    always @(posedge clk) begin
        csl_pkg::t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("result %0d unexpected: hit=%0b way=%0d",
                                 results_seen, out_data.hit, out_data.way_index);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (out_data.hit !== want.hit || out_data.way_index !== want.way_index) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT) begin
                            $display("result %0d: expected hit=%0b way=%0d, got hit=%0b way=%0d",
                                     results_seen, want.hit, want.way_index,
                                     out_data.hit, out_data.way_index);
                        end
                    end
                end
                if (sink_calm_left > 0) begin
                    sink_calm_left--;
                    stall_left = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    sink_calm_left = $urandom_range(20, 60);
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 13);
                end
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int                  kind;
        int                  span;
        int                  pool_size;
        int                  hot;
        bit                  first;
        bit                  drain;
        logic [LOOKUP_W-1:0] base;
        logic [LOOKUP_W-1:0] pool [8];

        for (int w = 0; w < NUM_WAYS; w++) begin
            way_live[w] = 1'b0;
            way_tag[w]  = '0;
            way_age[w]  = '0;
        end
        ways_filled = 0;

        // fill in order, hit, evict the oldest, then invalidate
        queue_request(csl_pkg::OP_ACCESS, 8'h00, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'hFF, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h00, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'hA5, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h5A, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'hFF, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h3C, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'hC3, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h01, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h3C, 1'b0);
        queue_request(csl_pkg::OP_INVALIDATE, 8'h00, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h3C, 1'b0);
        queue_request(csl_pkg::OP_INVALIDATE, 8'hFF, 1'b0);
        queue_request(csl_pkg::OP_INVALIDATE, 8'h55, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h80, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h7F, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h80, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h02, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h04, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h08, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'h7F, 1'b0);
        queue_request(csl_pkg::OP_ACCESS, 8'hFF, 1'b0);

        first = 1'b1;
        while (queued_total < TOTAL_ITEMS) begin
            kind = $urandom_range(0, 15);
            if (first) kind = 0;
            if (!first && kind == 0 && queued_total + 320 > TOTAL_ITEMS) kind = 12;
            drain = first || ($urandom_range(0, 7) == 0);
            first = 1'b0;
            if (kind == 0) begin
                // saturate three ages, then evict through the tie
                base = LOOKUP_W'($urandom);
                hot  = $urandom_range(0, NUM_WAYS - 1);
                queue_request(csl_pkg::OP_INVALIDATE, LOOKUP_W'($urandom), drain);
                for (int i = 0; i < NUM_WAYS; i++) begin
                    queue_request(csl_pkg::OP_ACCESS, LOOKUP_W'(base + i * 37), 1'b0);
                end
                span = $urandom_range(260, 300);
                for (int i = 0; i < span; i++) begin
                    queue_request(csl_pkg::OP_ACCESS, LOOKUP_W'(base + hot * 37), 1'b0);
                end
                for (int i = 0; i < 6; i++) begin
                    queue_request(csl_pkg::OP_ACCESS, LOOKUP_W'($urandom), 1'b0);
                end
            end else if (kind <= 11) begin
                pool_size = $urandom_range(2, 7);
                for (int i = 0; i < pool_size; i++) begin
                    pool[i] = LOOKUP_W'($urandom);
                end
                span = $urandom_range(20, 60);
                queue_request(csl_pkg::OP_ACCESS, pool[0], drain);
                for (int i = 0; i < span; i++) begin
                    if ($urandom_range(0, 39) == 0) begin
                        queue_request(csl_pkg::OP_INVALIDATE, LOOKUP_W'($urandom), 1'b0);
                    end else begin
                        queue_request(csl_pkg::OP_ACCESS,
                                      pool[$urandom_range(0, pool_size - 1)], 1'b0);
                    end
                end
            end else begin
                span = $urandom_range(10, 30);
                for (int i = 0; i < span; i++) begin
                    queue_request(($urandom_range(0, 7) == 0) ? csl_pkg::OP_INVALIDATE
                                                              : csl_pkg::OP_ACCESS,
                                  LOOKUP_W'($urandom), drain && (i == 0));
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (access_stream.size() != 0 || in_valid || awaited_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/csl_pkg.sv
rtl/csl_way_cmp.sv
rtl/cache_set_lru_lookup_fill.sv
rtl/cache_set_lru_lookup_fill_chk.sv
tb/tb_top.sv
